// ===== design/text_glyph_renderer_cursor_unit_macros.svh =====
// assertion macros for the text glyph renderer rtl
// expects clk and rst in the scope of each use
`ifndef TEXT_GLYPH_RENDERER_CURSOR_UNIT_MACROS_SVH
`define TEXT_GLYPH_RENDERER_CURSOR_UNIT_MACROS_SVH

// same-cycle implication, checked on every clock outside reset
`define TGR_ASSERT_IMPL(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("tgr assertion failed");

// next-cycle implication, checked on every clock outside reset
`define TGR_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("tgr assertion failed");

`endif

// ===== design/tgr_pkg.sv =====
// shared types and constants of the text glyph renderer
// no dependencies
package tgr_pkg;

  // glyph cell geometry in font pixels
  localparam int unsigned CELL_W     = 6;
  localparam int unsigned LINE_H     = 8;
  localparam int unsigned GLYPH_COLS = 5;
  localparam int unsigned GLYPH_ROWS = 7;

  // input opcodes
  localparam logic OP_PRINT = 1'b0;
  localparam logic OP_MOVE  = 1'b1;

  // character codes with a meaning of their own
  localparam logic [7:0] CHAR_BELL  = 8'h07;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TEXT_SCALE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WRAP_ENABLE   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TEXT_COLOR    = 3'd4;

  // glyph dot mask: column c, row r at bit c*8+r, bit 7 of each column unused
  localparam int unsigned MASK_W = 40;

  // configuration seen by the front and back parts, scale already nonzero
  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic [4:0]  scale;
    logic        wrap;
    logic [31:0] color;
  } tgr_cfg_t;

  // one classified item: dots to draw at a base, and the cursor afterwards
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [15:0]       base_x;
    logic [15:0]       base_y;
    logic [15:0]       cur_x;
    logic [15:0]       cur_y;
  } tgr_entry_t;

endpackage

// ===== design/tgr_front.sv =====
// front part: cursor state, command classification and font lookup
// depends on tgr_pkg
module tgr_front (
  input  logic                clk,
  input  logic                rst,
  input  tgr_pkg::tgr_cfg_t   cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                opcode,
  input  logic [7:0]          char_code,
  input  logic [15:0]         goto_x,
  input  logic [15:0]         goto_y,
  output logic                push_valid,
  input  logic                push_ready,
  output tgr_pkg::tgr_entry_t push_data
);
  import tgr_pkg::*;

  localparam int unsigned GLYPH_NUM = 95;
  localparam logic [MASK_W-1:0] ROW_MASK = 40'h7F7F7F7F7F;

  // 5x7 font, column 0 in the low byte, bit 0 the top row
  localparam logic [MASK_W-1:0] GLYPH_ROM [GLYPH_NUM] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h122A7F2A24, 40'h6264081323, 40'h5020564936, 40'h0003070800,
    40'h0041221C00, 40'h001C224100, 40'h2A1C7F1C2A, 40'h08083E0808,
    40'h0030708000, 40'h0808080808, 40'h0060600000, 40'h0204081020,
    40'h3E4549513E, 40'h00407F4200, 40'h4649494972, 40'h334D494121,
    40'h107F121418, 40'h3945454527, 40'h3149494A3C, 40'h0709112141,
    40'h3649494936, 40'h1E29494946, 40'h0000140000, 40'h0000344000,
    40'h4122140800, 40'h1414141414, 40'h0814224100, 40'h0609590102,
    40'h4E595D413E, 40'h7C1211127C, 40'h364949497F, 40'h224141413E,
    40'h3E4141417F, 40'h414949497F, 40'h010909097F, 40'h735141413E,
    40'h7F0808087F, 40'h00417F4100, 40'h013F414020, 40'h412214087F,
    40'h404040407F, 40'h7F021C027F, 40'h7F1008047F, 40'h3E4141413E,
    40'h060909097F, 40'h5E2151413E, 40'h462919097F, 40'h3249494926,
    40'h03017F0103, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0304780403, 40'h434D495961, 40'h4141417F00,
    40'h2010080402, 40'h7F41414100, 40'h0402010204, 40'h4040404040,
    40'h0008070300, 40'h4078545420, 40'h384444287F, 40'h2844444438,
    40'h7F28444438, 40'h1854545438, 40'h02097E0800, 40'h789CA4A418,
    40'h780404087F, 40'h00407D4400, 40'h003D404020, 40'h004428107F,
    40'h00407F4100, 40'h780478047C, 40'h780404087C, 40'h3844444438,
    40'h18242418FC, 40'hFC18242418, 40'h080404087C, 40'h2454545448,
    40'h24443F0404, 40'h7C2040403C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h7C9090904C, 40'h444C546444, 40'h0041360800,
    40'h0000770000, 40'h0008364100, 40'h0204020102
  };

  logic [15:0] cursor_x;
  logic [15:0] cursor_y;
  logic [15:0] cursor_x_next;
  logic [15:0] cursor_y_next;

  logic [7:0]  step6;
  logic [7:0]  step5;
  logic [7:0]  step7;
  logic [7:0]  step8;
  logic [15:0] adv_x;
  logic [15:0] clamp_x;
  logic [15:0] nl_y_raw;
  logic [15:0] nl_y;
  logic        wrap_hit;
  logic        printable;
  logic [7:0]  glyph_code;
  logic [6:0]  glyph_idx;
  logic        draw;
  logic        accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  // scaled cell steps
  always_comb begin
    step6 = 8'(cfg.scale) * 8'(CELL_W);
    step5 = 8'(cfg.scale) * 8'(GLYPH_COLS);
    step7 = 8'(cfg.scale) * 8'(GLYPH_ROWS);
    step8 = 8'(cfg.scale) * 8'(LINE_H);
  end

  // next line position, shared by line feed and wrap
  always_comb begin
    nl_y_raw = 16'(cursor_y + 16'(step8));
    nl_y     = ((17'(nl_y_raw) + 17'(step7)) > 17'(cfg.height)) ? '0 : nl_y_raw;
  end

  // advance after a glyph, clamp and line wrap test
  always_comb begin
    adv_x    = 16'(cursor_x + 16'(step6));
    clamp_x  = (17'(adv_x) > (17'(cfg.width) + 17'(step6))) ? cfg.width : adv_x;
    wrap_hit = cfg.wrap && ((17'(clamp_x) + 17'(step5)) > 17'(cfg.width));
  end

  // font index, unknown codes print a question mark
  always_comb begin
    printable  = (char_code >= CHAR_SPACE) && (char_code <= CHAR_TILDE);
    glyph_code = printable ? char_code : CHAR_QMARK;
    glyph_idx  = 7'(glyph_code - CHAR_SPACE);
  end

  // command classification and cursor update
  always_comb begin
    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    draw          = 1'b0;
    if (opcode == OP_MOVE) begin
      if ((goto_x < cfg.width) && (goto_y < cfg.height)) begin
        cursor_x_next = goto_x;
        cursor_y_next = goto_y;
      end
    end else if ((char_code == CHAR_SPACE) && (cursor_x == '0) && cfg.wrap) begin
      // leading space dropped
    end else if (char_code == CHAR_BELL) begin
      cursor_x_next = '0;
      cursor_y_next = '0;
    end else if ((char_code == CHAR_BS) && (cursor_x >= 16'(step6))) begin
      cursor_x_next = 16'(cursor_x - 16'(step6));
    end else if (char_code == CHAR_CR) begin
      cursor_x_next = '0;
    end else if (char_code == CHAR_LF) begin
      cursor_x_next = '0;
      cursor_y_next = nl_y;
    end else begin
      draw = 1'b1;
      if (wrap_hit) begin
        cursor_x_next = '0;
        cursor_y_next = nl_y;
      end else begin
        cursor_x_next = clamp_x;
      end
    end
  end

  // queue entry
  always_comb begin
    push_data.mask   = draw ? (GLYPH_ROM[glyph_idx] & ROW_MASK) : '0;
    push_data.base_x = cursor_x;
    push_data.base_y = cursor_y;
    push_data.cur_x  = cursor_x_next;
    push_data.cur_y  = cursor_y_next;
  end

  // cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
    end else if (accept) begin
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
    end
  end

endmodule

// ===== design/tgr_queue.sv =====
// short register queue between the front and back parts
// depends on tgr_pkg
module tgr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  tgr_pkg::tgr_entry_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output tgr_pkg::tgr_entry_t pop_data
);
  import tgr_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tgr_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

endmodule

// ===== design/tgr_back.sv =====
// back part: walks the dot mask of each entry and drives the result register
// depends on tgr_pkg and the assertion macro header
`include "text_glyph_renderer_cursor_unit_macros.svh"

module tgr_back (
  input  logic                clk,
  input  logic                rst,
  input  tgr_pkg::tgr_cfg_t   cfg,
  input  logic                q_valid,
  output logic                q_pop,
  input  tgr_pkg::tgr_entry_t q_data,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [103:0]        m_tdata,  // dot_x, dot_y, dot_size, dot_color,
                                        // cursor_x_after, cursor_y_after, zero pad
  output logic                m_tuser,  // dot_valid
  output logic                m_tlast   // last_of_item
);
  import tgr_pkg::*;

  localparam int unsigned POS_W = $clog2(MASK_W);

  // current entry
  logic              busy;
  logic [MASK_W-1:0] mask;
  logic [15:0]       base_x;
  logic [15:0]       base_y;
  logic [15:0]       cur_x;
  logic [15:0]       cur_y;

  // result register
  logic [15:0] dot_x_r;
  logic [15:0] dot_y_r;
  logic [4:0]  dot_size_r;
  logic [31:0] dot_color_r;
  logic [15:0] cur_x_r;
  logic [15:0] cur_y_r;

  logic [POS_W-1:0]  pos;
  logic [MASK_W-1:0] mask_rest;
  logic [7:0]        off_x;
  logic [7:0]        off_y;
  logic              emit;
  logic              finishing;
  logic              load;

  // lowest remaining dot
  always_comb begin
    pos = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (mask[i]) begin
        pos = POS_W'(i);
      end
    end
    mask_rest = mask & (mask - 1'b1);
  end

  // dot offsets from column and row
  always_comb begin
    off_x = 8'(pos[POS_W-1:3]) * 8'(cfg.scale);
    off_y = 8'(pos[2:0]) * 8'(cfg.scale);
  end

  // handshake between entry, queue and result register
  always_comb begin
    emit      = busy && (!m_tvalid || m_tready);
    finishing = emit && (mask_rest == '0);
    load      = q_valid && (!busy || finishing);
    q_pop     = load;
  end

  // entry walk
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (finishing) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mask   <= q_data.mask;
      base_x <= q_data.base_x;
      base_y <= q_data.base_y;
      cur_x  <= q_data.cur_x;
      cur_y  <= q_data.cur_y;
    end else if (emit) begin
      mask <= mask_rest;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result payload, an empty mask gives the single no-dot beat
  always_ff @(posedge clk) begin
    if (emit) begin
      cur_x_r <= cur_x;
      cur_y_r <= cur_y;
      m_tlast <= (mask_rest == '0);
      if (mask != '0) begin
        dot_x_r     <= 16'(base_x + 16'(off_x));
        dot_y_r     <= 16'(base_y + 16'(off_y));
        dot_size_r  <= cfg.scale;
        dot_color_r <= cfg.color;
        m_tuser     <= 1'b1;
      end else begin
        dot_x_r     <= '0;
        dot_y_r     <= '0;
        dot_size_r  <= '0;
        dot_color_r <= '0;
        m_tuser     <= 1'b0;
      end
    end
  end

  assign m_tdata = {3'b000, cur_y_r, cur_x_r, dot_color_r, dot_size_r, dot_y_r, dot_x_r};

  // checks
  `TGR_ASSERT_IMPL(a_nodot_is_last, m_tvalid && !m_tuser, m_tlast && (dot_size_r == '0))
  `TGR_ASSERT_IMPL(a_dot_has_size, m_tvalid && m_tuser, dot_size_r != '0)
  `TGR_ASSERT_NEXT(a_more_dots_follow, emit && (mask_rest != '0), busy && m_tvalid && !m_tlast)
  `TGR_ASSERT_NEXT(a_load_starts_walk, load, busy)

endmodule

// ===== design/text_glyph_renderer_cursor_unit.sv =====
// Text glyph renderer with cursor: top level with configuration registers.
// Input beats carry a character or a move command (s_* channel); each beat
// yields one or more dot beats on the m_* channel, 5x7 font scaled by text_scale.
// The last beat of an item has m_tlast set; m_tuser marks beats that carry a dot,
// a beat without a dot has zero position, size and color.
// Every beat carries the cursor position after its whole input item.
// An input beat is written to the queue and loaded into the entry register of
// the back part when that part is free; its first beat is then registered.
// Throughput: an item gives max(1, dots in glyph) beats, at most 35; the dot
// walk in the back part sends one dot per cycle while m_tready is high. Items
// are taken each cycle while the queue has room, so a walk overlaps the next
// items and beats leave back to back.
// cfg_* writes a register by index (0 width, 1 height, 2 scale, 3 wrap,
// 4 color); cfg_ready is always high; write only while the block is idle.
// Reset clears the cursor to (0, 0), empties the queue and result register,
// and loads 320, 240, 1, 1 and 0x00FFFFFF.
// When m_tready is low the result register holds; the queue then fills and
// s_tready drops.
// depends on tgr_pkg, tgr_front, tgr_queue, tgr_back
module text_glyph_renderer_cursor_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [39:0]                      s_tdata,  // char_code, goto_x, goto_y
  input  logic                             s_tuser,  // opcode
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [103:0]                     m_tdata,  // dot_x, dot_y, dot_size,
                                                     // dot_color, cursor_x_after,
                                                     // cursor_y_after, zero pad
  output logic                             m_tuser,  // dot_valid
  output logic                             m_tlast,  // last_of_item
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tgr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [31:0]                      cfg_data
);
  import tgr_pkg::*;

  logic [15:0] screen_width;
  logic [15:0] screen_height;
  logic [4:0]  text_scale;
  logic        wrap_enable;
  logic [31:0] text_color;

  tgr_cfg_t    cfg;
  tgr_entry_t  push_data;
  tgr_entry_t  pop_data;
  logic        push_valid;
  logic        push_ready;
  logic        pop_valid;
  logic        pop_ready;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 16'd320;
      screen_height <= 16'd240;
      text_scale    <= 5'd1;
      wrap_enable   <= 1'b1;
      text_color    <= 32'h00FF_FFFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[15:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[15:0];
        REG_TEXT_SCALE:    text_scale    <= cfg_data[4:0];
        REG_WRAP_ENABLE:   wrap_enable   <= cfg_data[0];
        REG_TEXT_COLOR:    text_color    <= cfg_data;
        default: ;
      endcase
    end
  end

  // scale zero acts as one
  always_comb begin
    cfg.width  = screen_width;
    cfg.height = screen_height;
    cfg.scale  = (text_scale == '0) ? 5'd1 : text_scale;
    cfg.wrap   = wrap_enable;
    cfg.color  = text_color;
  end

  tgr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .opcode     (s_tuser),
    .char_code  (s_tdata[7:0]),
    .goto_x     (s_tdata[23:8]),
    .goto_y     (s_tdata[39:24]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tgr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tgr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (pop_valid),
    .q_pop    (pop_ready),
    .q_data   (pop_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== bench/glyph_dot_checker.sv =====
`timescale 1ns / 100ps
// predicts and checks the dot beats of the text glyph renderer with cursor
// watches the input, result and register write channels; depends on tgr_pkg
module glyph_dot_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [39:0]                     s_tdata,
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [103:0]                    m_tdata,
  input  logic                            m_tuser,
  input  logic                            m_tlast,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [tgr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data,
  output int                              errors,
  output int                              pending
);
  import tgr_pkg::*;

  // keep the log short when a run goes badly wrong
  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [15:0] dot_x;
    logic [15:0] dot_y;
    logic [4:0]  size;
    logic [31:0] color;
    logic        valid;
    logic        last;
    logic [15:0] cur_x;
    logic [15:0] cur_y;
  } dot_beat_t;

  // register copy and cursor as the block should hold them
  logic [15:0] cfg_w;
  logic [15:0] cfg_h;
  logic [4:0]  cfg_scale;
  logic        cfg_wrap;
  logic [31:0] cfg_color;
  logic [15:0] cur_x;
  logic [15:0] cur_y;

  dot_beat_t beats_due[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report_error(input string msg);
    if (errors < PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // 5x7 font, columns left to right from the top byte down, bit 0 is the top row
  function automatic logic [39:0] glyph_columns(input logic [7:0] ch);
    logic [39:0] g;
    case (ch)
      8'h20: g = 40'h0000000000; 8'h21: g = 40'h00005F0000; 8'h22: g = 40'h0007000700;
      8'h23: g = 40'h147F147F14; 8'h24: g = 40'h242A7F2A12; 8'h25: g = 40'h2313086462;
      8'h26: g = 40'h3649562050; 8'h27: g = 40'h0008070300; 8'h28: g = 40'h001C224100;
      8'h29: g = 40'h0041221C00; 8'h2A: g = 40'h2A1C7F1C2A; 8'h2B: g = 40'h08083E0808;
      8'h2C: g = 40'h0080703000; 8'h2D: g = 40'h0808080808; 8'h2E: g = 40'h0000606000;
      8'h2F: g = 40'h2010080402; 8'h30: g = 40'h3E5149453E; 8'h31: g = 40'h00427F4000;
      8'h32: g = 40'h7249494946; 8'h33: g = 40'h2141494D33; 8'h34: g = 40'h1814127F10;
      8'h35: g = 40'h2745454539; 8'h36: g = 40'h3C4A494931; 8'h37: g = 40'h4121110907;
      8'h38: g = 40'h3649494936; 8'h39: g = 40'h464949291E; 8'h3A: g = 40'h0000140000;
      8'h3B: g = 40'h0040340000; 8'h3C: g = 40'h0008142241; 8'h3D: g = 40'h1414141414;
      8'h3E: g = 40'h0041221408; 8'h3F: g = 40'h0201590906; 8'h40: g = 40'h3E415D594E;
      8'h41: g = 40'h7C1211127C; 8'h42: g = 40'h7F49494936; 8'h43: g = 40'h3E41414122;
      8'h44: g = 40'h7F4141413E; 8'h45: g = 40'h7F49494941; 8'h46: g = 40'h7F09090901;
      8'h47: g = 40'h3E41415173; 8'h48: g = 40'h7F0808087F; 8'h49: g = 40'h00417F4100;
      8'h4A: g = 40'h2040413F01; 8'h4B: g = 40'h7F08142241; 8'h4C: g = 40'h7F40404040;
      8'h4D: g = 40'h7F021C027F; 8'h4E: g = 40'h7F0408107F; 8'h4F: g = 40'h3E4141413E;
      8'h50: g = 40'h7F09090906; 8'h51: g = 40'h3E4151215E; 8'h52: g = 40'h7F09192946;
      8'h53: g = 40'h2649494932; 8'h54: g = 40'h03017F0103; 8'h55: g = 40'h3F4040403F;
      8'h56: g = 40'h1F2040201F; 8'h57: g = 40'h3F4038403F; 8'h58: g = 40'h6314081463;
      8'h59: g = 40'h0304780403; 8'h5A: g = 40'h6159494D43; 8'h5B: g = 40'h007F414141;
      8'h5C: g = 40'h0204081020; 8'h5D: g = 40'h004141417F; 8'h5E: g = 40'h0402010204;
      8'h5F: g = 40'h4040404040; 8'h60: g = 40'h0003070800; 8'h61: g = 40'h2054547840;
      8'h62: g = 40'h7F28444438; 8'h63: g = 40'h3844444428; 8'h64: g = 40'h384444287F;
      8'h65: g = 40'h3854545418; 8'h66: g = 40'h00087E0902; 8'h67: g = 40'h18A4A49C78;
      8'h68: g = 40'h7F08040478; 8'h69: g = 40'h00447D4000; 8'h6A: g = 40'h2040403D00;
      8'h6B: g = 40'h7F10284400; 8'h6C: g = 40'h00417F4000; 8'h6D: g = 40'h7C04780478;
      8'h6E: g = 40'h7C08040478; 8'h6F: g = 40'h3844444438; 8'h70: g = 40'hFC18242418;
      8'h71: g = 40'h18242418FC; 8'h72: g = 40'h7C08040408; 8'h73: g = 40'h4854545424;
      8'h74: g = 40'h04043F4424; 8'h75: g = 40'h3C4040207C; 8'h76: g = 40'h1C2040201C;
      8'h77: g = 40'h3C4030403C; 8'h78: g = 40'h4428102844; 8'h79: g = 40'h4C9090907C;
      8'h7A: g = 40'h4464544C44; 8'h7B: g = 40'h0008364100; 8'h7C: g = 40'h0000770000;
      8'h7D: g = 40'h0041360800; 8'h7E: g = 40'h0201020402;
      default: g = 40'h0;
    endcase
    return g;
  endfunction

  // y of the next text line, back to the top when a glyph would not fit
  function automatic int unsigned line_below(input int unsigned y, input int unsigned s);
    int unsigned ny;
    ny = (y + s * LINE_H) & 32'hFFFF;
    if (ny + s * GLYPH_ROWS > cfg_h) ny = 0;
    return ny;
  endfunction

  // work out the dot beats of one input item and move the cursor
  task automatic render_item(input logic op, input logic [7:0] code,
                             input logic [15:0] gx, input logic [15:0] gy);
    int unsigned s;
    int unsigned cx;
    int unsigned cy;
    int unsigned col;
    logic [7:0]  ch;
    logic [39:0] cols;
    logic        draw;
    dot_beat_t   b;
    dot_beat_t   dots[$];
    s    = (cfg_scale == 5'd0) ? 1 : cfg_scale;
    cx   = cur_x;
    cy   = cur_y;
    ch   = code;
    draw = 1'b0;
    if (op == OP_MOVE) begin
      if (gx < cfg_w && gy < cfg_h) begin
        cx = gx;
        cy = gy;
      end
    end else if (code == CHAR_SPACE && cx == 0 && cfg_wrap) begin
      // leading space while wrapping draws nothing
    end else if (code == CHAR_BELL) begin
      cx = 0;
      cy = 0;
    end else if (code == CHAR_BS && cx >= s * CELL_W) begin
      cx = cx - s * CELL_W;
    end else if (code == CHAR_CR) begin
      cx = 0;
    end else if (code == CHAR_LF) begin
      cx = 0;
      cy = line_below(cy, s);
    end else begin
      draw = 1'b1;
    end

    if (draw) begin
      if (ch < CHAR_SPACE || ch > CHAR_TILDE) ch = CHAR_QMARK;
      cols = glyph_columns(ch);
      // dots column by column, top to bottom
      for (int unsigned i = 0; i < GLYPH_COLS; i++) begin
        col = cols[39 - 8 * i -: 8] & 32'h7F;
        for (int unsigned j = 0; j < GLYPH_ROWS; j++) begin
          if (col[j]) begin
            b       = '0;
            b.dot_x = 16'(cx + i * s);
            b.dot_y = 16'(cy + j * s);
            b.size  = 5'(s);
            b.color = cfg_color;
            b.valid = 1'b1;
            dots.push_back(b);
          end
        end
      end
      // advance, clamp and wrap
      cx = (cx + s * CELL_W) & 32'hFFFF;
      if (cx > cfg_w + s * CELL_W) cx = cfg_w;
      if (cfg_wrap && cx + s * GLYPH_COLS > cfg_w) begin
        cx = 0;
        cy = line_below(cy, s);
      end
    end

    // an item with no dot still gives one empty beat
    if (dots.size() == 0) begin
      b = '0;
      dots.push_back(b);
    end
    foreach (dots[k]) begin
      dots[k].last  = (k == dots.size() - 1);
      dots[k].cur_x = 16'(cx);
      dots[k].cur_y = 16'(cy);
      beats_due.push_back(dots[k]);
    end
    cur_x = 16'(cx);
    cur_y = 16'(cy);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_error($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // compare one result beat with the oldest prediction
  task automatic check_beat();
    dot_beat_t want;
    if (beats_due.size() == 0) begin
      report_error($sformatf("beat with nothing predicted, tdata %h", m_tdata));
    end else begin
      want = beats_due.pop_front();
      check_field("dot_x", m_tdata[15:0], want.dot_x);
      check_field("dot_y", m_tdata[31:16], want.dot_y);
      check_field("dot_size", m_tdata[36:32], want.size);
      check_field("dot_color", m_tdata[68:37], want.color);
      check_field("dot_valid", m_tuser, want.valid);
      check_field("last_of_item", m_tlast, want.last);
      check_field("cursor_x_after", m_tdata[84:69], want.cur_x);
      check_field("cursor_y_after", m_tdata[100:85], want.cur_y);
    end
  endtask

  // channel monitor
  always @(posedge clk) begin
    if (rst) begin
      cfg_w     = 16'd320;
      cfg_h     = 16'd240;
      cfg_scale = 5'd1;
      cfg_wrap  = 1'b1;
      cfg_color = 32'h00FF_FFFF;
      cur_x     = 16'd0;
      cur_y     = 16'd0;
      beats_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:  cfg_w = cfg_data[15:0];
          REG_SCREEN_HEIGHT: cfg_h = cfg_data[15:0];
          REG_TEXT_SCALE:    cfg_scale = cfg_data[4:0];
          REG_WRAP_ENABLE:   cfg_wrap = cfg_data[0];
          REG_TEXT_COLOR:    cfg_color = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) check_beat();
      if (s_tvalid && s_tready)
        render_item(s_tuser, s_tdata[7:0], s_tdata[23:8], s_tdata[39:24]);
    end
    pending = beats_due.size();
  end

endmodule

// ===== bench/tb_text_glyph_renderer_cursor_unit.sv =====
`timescale 1ns / 100ps
// top of the text glyph renderer bench: clock, reset, stimulus and verdict
// depends on tgr_pkg, text_glyph_renderer_cursor_unit and glyph_dot_checker
module tb_text_glyph_renderer_cursor_unit;
  import tgr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_SPARSE,
    RX_EVERY_THIRD,
    RX_COIN
  } rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [39:0]            s_tdata = '0;   // char_code, goto_x, goto_y
  logic                   s_tuser = 1'b0; // opcode
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [103:0]           m_tdata;        // dot_x, dot_y, dot_size, dot_color,
                                          // cursor_x_after, cursor_y_after, pad
  logic                   m_tuser;        // dot_valid
  logic                   m_tlast;        // last_of_item
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]            cfg_data = '0;

  int          mismatches;
  int          beats_pending;
  int          cycle_count = 0;
  int unsigned rx_tick = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  int          burst_left = 0;
  logic        tx_eager = 1'b0;
  logic [15:0] cur_w = 16'd320;
  logic [15:0] cur_h = 16'd240;

  text_glyph_renderer_cursor_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  glyph_dot_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (mismatches),
    .pending   (beats_pending)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_text_glyph_renderer_cursor_unit: errors");
      $finish;
    end
  end

  // result side back-pressure, the pattern chosen at random from four modes
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 300 == 299) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:        m_tready <= 1'b1;
      RX_SPARSE:      m_tready <= ($urandom_range(0, 3) == 0);
      RX_EVERY_THIRD: m_tready <= (rx_tick % 3 == 0);
      default:        m_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  // one input beat, in bursts with random gaps between them
  task automatic drive_item(input logic op, input logic [7:0] code,
                            input logic [15:0] gx, input logic [15:0] gy);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = tx_eager ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {gy, gx, code};
    do @(posedge clk); while (!s_tready);
    burst_left--;
  endtask

  task automatic put_char(input logic [7:0] code);
    drive_item(OP_PRINT, code, 16'($urandom), 16'($urandom));
  endtask

  task automatic go_to(input logic [15:0] gx, input logic [15:0] gy);
    drive_item(OP_MOVE, 8'($urandom), gx, gy);
  endtask

  // hold the sender until every predicted beat has come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (beats_pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // write all registers, unused upper data bits random
  task automatic apply_cfg(input logic [15:0] w, input logic [15:0] h,
                           input logic [4:0] sc, input logic wr, input logic [31:0] color);
    logic [31:0] junk;
    junk  = $urandom;
    cur_w = w;
    cur_h = h;
    write_reg(REG_SCREEN_WIDTH, {junk[31:16], w});
    write_reg(REG_SCREEN_HEIGHT, {junk[15:0], h});
    write_reg(REG_TEXT_SCALE, {junk[31:5], sc});
    write_reg(REG_WRAP_ENABLE, {junk[31:1], wr});
    write_reg(REG_TEXT_COLOR, color);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_cfg();
    logic [15:0] w;
    logic [15:0] h;
    logic [4:0]  sc;
    w  = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(1, 400))
                                     : 16'($urandom_range(1, 65535));
    h  = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(1, 300))
                                     : 16'($urandom_range(1, 65535));
    sc = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(1, 4))
                                     : 5'($urandom_range(0, 31));
    apply_cfg(w, h, sc, 1'($urandom_range(0, 1)), $urandom);
  endtask

  // mostly text with line control, some stray bytes and cursor moves
  task automatic send_random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      put_char(8'($urandom_range(8'h21, 8'h7E)));
    end else if (pick < 65) begin
      put_char(CHAR_SPACE);
    end else if (pick < 75) begin
      case ($urandom_range(0, 3))
        0:       put_char(CHAR_BELL);
        1:       put_char(CHAR_BS);
        2:       put_char(CHAR_CR);
        default: put_char(CHAR_LF);
      endcase
    end else if (pick < 82) begin
      put_char(8'($urandom));
    end else if (pick < 94) begin
      go_to(16'($urandom_range(0, cur_w - 1)), 16'($urandom_range(0, cur_h - 1)));
    end else begin
      go_to(16'($urandom), 16'($urandom));
    end
  endtask

  task automatic random_items(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 59) == 0) drain_results();
      send_random_item();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: glyphs, control codes, stray codes, moves
    put_char(8'h41);           // 'A' at the origin
    put_char(CHAR_TILDE);
    put_char(CHAR_SPACE);      // space away from the left edge draws a blank cell
    put_char(CHAR_BS);
    put_char(CHAR_CR);
    put_char(CHAR_SPACE);      // leading space is skipped
    put_char(CHAR_BS);         // backspace at the left edge prints a question mark
    put_char(CHAR_LF);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(8'h7F);
    put_char(CHAR_BELL);
    go_to(16'd320, 16'd10);    // off screen in x
    go_to(16'd10, 16'd240);    // off screen in y
    go_to(16'd319, 16'd239);
    put_char(8'h40);           // wraps to the next line and back to the top
    go_to(16'd0, 16'd232);
    put_char(CHAR_LF);
    drain_results();

    // widest screen, largest scale, no wrap: dot positions roll over
    tx_eager = 1'b1;
    apply_cfg(16'hFFFF, 16'hFFFF, 5'd31, 1'b0, 32'hFFFF_FFFF);
    go_to(16'hFFFE, 16'hFFFE);
    put_char(8'h4D);
    go_to(16'd0, 16'd0);
    put_char(CHAR_SPACE);      // no wrap, so a leading space draws a blank cell
    random_items(40);
    drain_results();

    // one pixel screen, no wrap: the cursor clamps to the width
    tx_eager = 1'b0;
    apply_cfg(16'd1, 16'd1, 5'd1, 1'b0, 32'h0);
    put_char(8'h57);
    put_char(8'h57);
    put_char(8'h57);
    put_char(CHAR_LF);
    random_items(30);
    drain_results();

    // scale zero acts as one
    apply_cfg(16'd100, 16'd50, 5'd0, 1'b1, $urandom);
    put_char(8'h42);
    put_char(CHAR_BS);
    random_items(40);
    drain_results();

    for (int ph = 0; ph < 5; ph++) begin
      tx_eager = (ph == 1) || ($urandom_range(0, 3) == 0);
      random_cfg();
      random_items(74);
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && beats_pending == 0)
      $display("tb_text_glyph_renderer_cursor_unit: clean");
    else
      $display("tb_text_glyph_renderer_cursor_unit: errors");
    $finish;
  end

endmodule
